### hw/rtl/gsa_pkg.sv
package gsa_pkg;

  // Default sizing of the slot table.
  localparam int SLOTS_DEF    = 4;
  localparam int GEN_BITS_DEF = 32;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_HEAP_ID   = 2'd0,
    REG_BASE_ADDR = 2'd1,
    REG_STRIDE    = 2'd2
  } gsa_reg_t;

  // Command codes carried by an input item.
  typedef enum logic [2:0] {
    OP_ALLOC    = 3'd0,
    OP_RELEASE  = 3'd1,
    OP_LOOKUP   = 3'd2,
    OP_SHUTDOWN = 3'd3,
    OP_PRESET   = 3'd4
  } gsa_op_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHUT_DOWN = 3'd1,
    ST_CAP_EXH   = 3'd2,
    ST_GEN_EXH   = 3'd3,
    ST_BAD_INDEX = 3'd4,
    ST_STALE     = 3'd5,
    ST_LIVE      = 3'd6
  } gsa_status_t;

  // One input item.
  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] slot_heap_id;
    logic [7:0]  slot_index;
    logic [31:0] slot_generation;
    logic [31:0] new_generation;
  } gsa_in_t;

  // One result item.
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_heap_id;
    logic [7:0]  out_index;
    logic [31:0] out_generation;
    logic [47:0] handle_address;
    logic [7:0]  live_count;
  } gsa_out_t;

  // Step commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic fetch;
    logic commit;
  } gsa_ctl_t;

endpackage

### hw/rtl/gsa_ram.sv
module gsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/gsa_ctrl.sv
module gsa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output gsa_pkg::gsa_ctl_t ctl
);

  import gsa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Each item walks through a read step and a commit step.
  always_comb begin
    state_nxt  = state_r;
    ctl.load   = 1'b0;
    ctl.fetch  = 1'b0;
    ctl.commit = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        ctl.fetch = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        ctl.commit = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

### hw/rtl/gsa_dp.sv
module gsa_dp #(
  parameter int SLOTS    = gsa_pkg::SLOTS_DEF,
  parameter int GEN_BITS = gsa_pkg::GEN_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [47:0]       cfg_wdata,
  input  gsa_pkg::gsa_in_t  in_item,
  input  gsa_pkg::gsa_ctl_t ctl,
  output logic              out_valid,
  output gsa_pkg::gsa_out_t out_item
);

  import gsa_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [7:0]       SLOTS_IDX = 8'(SLOTS);
  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

  // Configuration registers.
  logic [31:0] heap_id_r;
  logic [47:0] base_r;
  logic [15:0] stride_r;

  // Captured item and per-item working registers.
  gsa_in_t          item_r;
  logic [IDX_W-1:0] addr_r;
  logic [IDX_W-1:0] addr_nxt;
  logic             found_r;
  logic [23:0]      prod_r;

  // Table state: busy marks, all-ones generation flags, written flags.
  logic [SLOTS-1:0] busy_r,  busy_nxt;
  logic [SLOTS-1:0] full_r,  full_nxt;
  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0] used_r,  used_nxt;
  logic             open_r,  open_nxt;

  logic             out_valid_r;
  gsa_out_t         out_r;
  gsa_out_t         out_nxt;

  // Generation store signals.
  logic                ram_we;
  logic [GEN_BITS-1:0] ram_wdata;
  logic [GEN_BITS-1:0] ram_q;
  logic [GEN_BITS-1:0] cur_gen;
  logic [GEN_BITS-1:0] inc_gen;
  logic [GEN_BITS-1:0] new_gen;
  logic [GEN_BITS-1:0] cmp_gen;

  logic             sel_found;
  logic [IDX_W-1:0] sel_idx;
  logic             idx_ok;
  logic             live;

  // First free slot whose generation can still be bumped.
  always_comb begin
    sel_found = 1'b0;
    sel_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_r[i] && !full_r[i]) begin
        sel_found = 1'b1;
        sel_idx   = IDX_W'(i);
      end
    end
  end

  // Allocation targets the selected slot, everything else the handle index.
  assign addr_nxt = (item_r.cmd == OP_ALLOC) ? sel_idx : item_r.slot_index[IDX_W-1:0];

  gsa_ram #(
    .WIDTH (GEN_BITS),
    .DEPTH (SLOTS)
  ) u_gen_ram (
    .clk   (clk),
    .we    (ram_we & ctl.commit),
    .waddr (addr_r),
    .wdata (ram_wdata),
    .re    (ctl.fetch),
    .raddr (addr_nxt),
    .rdata (ram_q)
  );

  // An entry never written since reset or shutdown reads as zero.
  assign cur_gen = valid_r[addr_r] ? ram_q : '0;
  assign inc_gen = GEN_BITS'(cur_gen + 1'b1);
  assign new_gen = GEN_BITS'(item_r.new_generation);
  assign cmp_gen = GEN_BITS'(item_r.slot_generation);
  assign idx_ok  = (item_r.slot_index < SLOTS_IDX);
  assign live    = (item_r.slot_heap_id == heap_id_r) && busy_r[addr_r] &&
                   (cur_gen == cmp_gen);

  // Command execution: next table state and the result item.
  always_comb begin
    busy_nxt  = busy_r;
    full_nxt  = full_r;
    valid_nxt = valid_r;
    used_nxt  = used_r;
    open_nxt  = open_r;
    ram_we    = 1'b0;
    ram_wdata = new_gen;
    out_nxt   = '0;
    out_nxt.status = ST_OK;
    case (item_r.cmd)
      OP_ALLOC: begin
        if (!open_r) begin
          out_nxt.status = ST_SHUT_DOWN;
        end else if (found_r) begin
          ram_we                 = 1'b1;
          ram_wdata              = inc_gen;
          valid_nxt[addr_r]      = 1'b1;
          busy_nxt[addr_r]       = 1'b1;
          full_nxt[addr_r]       = (inc_gen == '1);
          used_nxt               = CNT_W'(used_r + 1'b1);
          out_nxt.out_heap_id    = heap_id_r;
          out_nxt.out_index      = 8'(addr_r);
          out_nxt.out_generation = 32'(inc_gen);
        end else if (used_r < SLOTS_CNT) begin
          out_nxt.status = ST_GEN_EXH;
        end else begin
          out_nxt.status = ST_CAP_EXH;
        end
      end
      OP_RELEASE, OP_LOOKUP: begin
        if (!idx_ok) begin
          out_nxt.status = ST_BAD_INDEX;
        end else if (!live) begin
          out_nxt.status = ST_STALE;
        end else if (item_r.cmd == OP_RELEASE) begin
          busy_nxt[addr_r] = 1'b0;
          used_nxt         = CNT_W'(used_r - 1'b1);
        end else begin
          out_nxt.handle_address = base_r + 48'(prod_r);
        end
      end
      OP_SHUTDOWN: begin
        if (open_r) begin
          if (used_r != '0) begin
            out_nxt.status = ST_LIVE;
          end else begin
            open_nxt  = 1'b0;
            valid_nxt = '0;
            busy_nxt  = '0;
            full_nxt  = '0;
          end
        end
      end
      OP_PRESET: begin
        if (idx_ok && !busy_r[addr_r]) begin
          ram_we            = 1'b1;
          valid_nxt[addr_r] = 1'b1;
          full_nxt[addr_r]  = (new_gen == '1);
        end
      end
      default: begin
      end
    endcase
    out_nxt.live_count = 8'(used_nxt);
  end

  // Control state: configuration, table flags, result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_id_r   <= 32'd1;
      base_r      <= '0;
      stride_r    <= 16'd1;
      busy_r      <= '0;
      full_r      <= '0;
      valid_r     <= '0;
      used_r      <= '0;
      open_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HEAP_ID:   heap_id_r <= cfg_wdata[31:0];
          REG_BASE_ADDR: base_r    <= cfg_wdata;
          REG_STRIDE:    stride_r  <= cfg_wdata[15:0];
          default: begin
          end
        endcase
      end
      if (ctl.commit) begin
        busy_r  <= busy_nxt;
        full_r  <= full_nxt;
        valid_r <= valid_nxt;
        used_r  <= used_nxt;
        open_r  <= open_nxt;
      end
      out_valid_r <= ctl.commit;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_r <= in_item;
    end
    if (ctl.fetch) begin
      addr_r  <= addr_nxt;
      found_r <= sel_found;
      prod_r  <= 24'(item_r.slot_index) * 24'(stride_r);
    end
    if (ctl.commit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

### hw/rtl/generational_slot_allocator_core.sv
// Generational slot allocator.
//
// Hands out descriptor slots as handles (heap id, index, generation) and
// checks handles on release and lookup. A command item is taken at a clock
// edge where start is high and busy is low; busy stays high while the item
// is worked on. Each item yields exactly one result item, shown on out_item
// for one cycle with out_valid high. The receiver cannot stall the block.
//
// The item is captured at the accepting edge; the generation store read is
// then registered, and the commit step registers the result, which is shown
// in the cycle after the commit edge. A new item can be taken at the edge
// that ends the result cycle, so the block cannot take an item before the
// result of the last one is shown.
//
// Configuration registers (heap id, base address, slot stride) must be
// written through cfg_we/cfg_index/cfg_wdata while the block is idle; the
// block itself does not enforce this. Reset opens the table, frees every
// slot and zeroes every generation at once; no clearing pass is needed.
module generational_slot_allocator_core #(
  parameter int SLOTS    = gsa_pkg::SLOTS_DEF,
  parameter int GEN_BITS = gsa_pkg::GEN_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [47:0]       cfg_wdata,
  input  logic              start,
  output logic              busy,
  input  gsa_pkg::gsa_in_t  in_item,
  output logic              out_valid,
  output gsa_pkg::gsa_out_t out_item
);

  import gsa_pkg::*;

  gsa_ctl_t ctl;

  // Sequencer for the steps of one item.
  gsa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctl   (ctl)
  );

  // Slot table, configuration and result logic.
  gsa_dp #(
    .SLOTS    (SLOTS),
    .GEN_BITS (GEN_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .ctl       (ctl),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

### bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gsa_pkg::*;

  localparam int SLOTS          = SLOTS_DEF;
  localparam int CMD_MAX        = 7;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 200;

  // How the driver completes a queued command once the table state is known.
  typedef enum int {
    FILL_AS_IS,
    FILL_LIVE,
    FILL_NEAR,
    FILL_GUARDED_SHUTDOWN
  } fill_kind_t;

  typedef struct {
    fill_kind_t fill;
    gsa_in_t    item;
  } queued_cmd_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = REG_HEAP_ID;
  logic [47:0] cfg_wdata = '0;
  logic        start     = 1'b0;
  logic        busy;
  gsa_in_t     in_item   = '0;
  logic        out_valid;
  gsa_out_t    out_item;

  // Shadow of the slot table and its registers.
  logic [31:0] heap_id_reg = 32'd1;
  logic [47:0] base_reg    = '0;
  logic [15:0] stride_reg  = 16'd1;
  logic [31:0] slot_gen [SLOTS];
  logic        slot_busy [SLOTS];
  int          live_slots;
  logic        table_open;

  queued_cmd_t pending_commands [$];
  gsa_out_t    predicted_replies [$];
  logic        cmd_offered  = 1'b0;
  int          idle_left    = 0;
  int          idle_pct     = 0;
  int          mismatch_count = 0;
  int          replies_seen = 0;
  int          quiet_cycles = 0;

  generational_slot_allocator_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Applies one command to the shadow table and returns the reply it must produce.
  function automatic gsa_out_t predict_reply(gsa_in_t it);
    gsa_out_t r;
    logic     found;
    r = '0;
    case (it.cmd)
      OP_ALLOC: begin
        if (!table_open) begin
          r.status = ST_SHUT_DOWN;
        end else begin
          found = 1'b0;
          for (int k = 0; k < SLOTS; k++) begin
            if (!found && !slot_busy[k] && slot_gen[k] != 32'hFFFF_FFFF) begin
              slot_gen[k]      = slot_gen[k] + 32'd1;
              slot_busy[k]     = 1'b1;
              live_slots++;
              r.out_heap_id    = heap_id_reg;
              r.out_index      = 8'(k);
              r.out_generation = slot_gen[k];
              found            = 1'b1;
            end
          end
          if (!found) begin
            r.status = (live_slots < SLOTS) ? ST_GEN_EXH : ST_CAP_EXH;
          end
        end
      end
      OP_RELEASE, OP_LOOKUP: begin
        if (it.slot_index >= SLOTS) begin
          r.status = ST_BAD_INDEX;
        end else if (!(it.slot_heap_id == heap_id_reg && slot_busy[it.slot_index] &&
                       slot_gen[it.slot_index] == it.slot_generation)) begin
          r.status = ST_STALE;
        end else if (it.cmd == OP_RELEASE) begin
          slot_busy[it.slot_index] = 1'b0;
          live_slots--;
        end else begin
          r.handle_address = base_reg + it.slot_index * stride_reg;
        end
      end
      OP_SHUTDOWN: begin
        if (table_open) begin
          if (live_slots != 0) begin
            r.status = ST_LIVE;
          end else begin
            table_open = 1'b0;
            for (int k = 0; k < SLOTS; k++) begin
              slot_gen[k]  = '0;
              slot_busy[k] = 1'b0;
            end
          end
        end
      end
      OP_PRESET: begin
        if (it.slot_index < SLOTS && !slot_busy[it.slot_index]) begin
          slot_gen[it.slot_index] = it.new_generation;
        end
      end
      default: ;
    endcase
    r.live_count = 8'(live_slots);
    return r;
  endfunction

  // Fills in handle fields from the shadow table where asked; guarded shutdowns become allocs if no slot is live.
  function automatic gsa_in_t shape_item(queued_cmd_t q);
    gsa_in_t it;
    int      busy_list [$];
    int      pick;
    it = q.item;
    if (q.fill == FILL_GUARDED_SHUTDOWN) begin
      it.cmd = (live_slots != 0) ? OP_SHUTDOWN : OP_ALLOC;
    end else if (q.fill != FILL_AS_IS) begin
      for (int k = 0; k < SLOTS; k++) begin
        if (slot_busy[k]) busy_list.push_back(k);
      end
      if (busy_list.size() != 0) begin
        pick = busy_list[$urandom_range(0, busy_list.size() - 1)];
        it.slot_heap_id    = heap_id_reg;
        it.slot_index      = 8'(pick);
        it.slot_generation = slot_gen[pick];
        // A near miss spoils exactly one part of a live handle.
        if (q.fill == FILL_NEAR) begin
          case ($urandom_range(0, 2))
            0: it.slot_heap_id = it.slot_heap_id ^ (32'd1 << $urandom_range(0, 31));
            1: it.slot_generation = it.slot_generation +
                                    ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
            default: it.slot_index = 8'((pick + $urandom_range(1, SLOTS - 1)) % SLOTS);
          endcase
        end
      end
    end
    return it;
  endfunction

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    if (mismatch_count < REPORT_LIMIT) begin
      $display("ERROR: reply %0d %s: got %0h, expected %0h", replies_seen, what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic check_field(string what, logic [47:0] got, logic [47:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic queue_item(fill_kind_t fill, logic [2:0] cmd, logic [31:0] hid,
                            logic [7:0] idx, logic [31:0] gen, logic [31:0] ngen);
    queued_cmd_t q;
    q.fill                 = fill;
    q.item.cmd             = cmd;
    q.item.slot_heap_id    = hid;
    q.item.slot_index      = idx;
    q.item.slot_generation = gen;
    q.item.new_generation  = ngen;
    pending_commands.push_back(q);
  endtask

  // Random traffic: allocations and real handles, with near misses, junk, presets, shutdowns and bad commands mixed in.
  task automatic queue_random(int count, bit may_close);
    int          roll;
    logic [2:0]  op;
    logic [31:0] ngen;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      op   = $urandom_range(0, 1) ? OP_RELEASE : OP_LOOKUP;
      if (roll < 35) begin
        queue_item(FILL_AS_IS, OP_ALLOC, $urandom, 8'($urandom), $urandom, $urandom);
      end else if (roll < 70) begin
        queue_item(FILL_LIVE, op, heap_id_reg, 8'($urandom_range(0, SLOTS - 1)),
                   $urandom_range(0, 3), $urandom);
      end else if (roll < 80) begin
        queue_item(FILL_NEAR, op, heap_id_reg, 8'($urandom_range(0, SLOTS - 1)),
                   $urandom_range(0, 3), $urandom);
      end else if (roll < 86) begin
        queue_item(FILL_AS_IS, op, $urandom_range(0, 1) ? heap_id_reg : $urandom,
                   $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, SLOTS + 1)),
                   $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4), $urandom);
      end else if (roll < 93) begin
        case ($urandom_range(0, 5))
          0:       ngen = 32'hFFFF_FFFF;
          1:       ngen = 32'hFFFF_FFFE;
          2:       ngen = $urandom_range(0, 3);
          default: ngen = $urandom;
        endcase
        queue_item(FILL_AS_IS, OP_PRESET, $urandom,
                   $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, SLOTS + 1)),
                   $urandom, ngen);
      end else if (roll < 96) begin
        queue_item(may_close ? FILL_AS_IS : FILL_GUARDED_SHUTDOWN, OP_SHUTDOWN,
                   $urandom, 8'($urandom), $urandom, $urandom);
      end else begin
        queue_item(FILL_AS_IS, 3'($urandom_range(OP_PRESET + 1, CMD_MAX)), $urandom,
                   8'($urandom), $urandom, $urandom);
      end
    end
  endtask

  // Waits until every queued command is taken and every reply is in, then lets the block settle.
  task automatic drain();
    while (pending_commands.size() != 0 || cmd_offered || predicted_replies.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(gsa_reg_t idx, logic [47:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_HEAP_ID:   heap_id_reg = val[31:0];
      REG_BASE_ADDR: base_reg    = val;
      REG_STRIDE:    stride_reg  = val[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(logic [31:0] heap, logic [47:0] base, logic [15:0] stride);
    // Bits above the heap id's and stride's widths are junk the block must drop.
    write_reg(REG_HEAP_ID, {16'($urandom), heap});
    write_reg(REG_BASE_ADDR, base);
    write_reg(REG_STRIDE, {32'($urandom), stride});
  endtask

  // Sender: presents queued commands, predicting each reply as its item is taken.
  always @(posedge clk) begin : drive
    logic offer;
    if (rst_n) begin
      offer = start;
      if (start && !busy) begin
        predicted_replies.push_back(predict_reply(in_item));
        offer       = 1'b0;
        cmd_offered = 1'b0;
      end
      if (!offer) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (pending_commands.size() != 0) begin
          if ($urandom_range(1, 100) <= idle_pct) begin
            idle_left = $urandom_range(0, 9);
          end else begin
            in_item     <= shape_item(pending_commands.pop_front());
            offer       = 1'b1;
            cmd_offered = 1'b1;
          end
        end
      end
      start <= offer;
    end
  end

  // Receiver: every strobed reply is matched against the oldest prediction.
  always @(posedge clk) begin : check
    gsa_out_t want;
    if (rst_n && out_valid) begin
      replies_seen++;
      if (predicted_replies.size() == 0) begin
        report_mismatch("arrived with no command outstanding", out_item.status, '0);
      end else begin
        want = predicted_replies.pop_front();
        check_field("status", out_item.status, want.status);
        check_field("out_heap_id", out_item.out_heap_id, want.out_heap_id);
        check_field("out_index", out_item.out_index, want.out_index);
        check_field("out_generation", out_item.out_generation, want.out_generation);
        check_field("handle_address", out_item.handle_address, want.handle_address);
        check_field("live_count", out_item.live_count, want.live_count);
      end
    end
  end

  // The run is abandoned if nothing moves on either side for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [31:0] h;
    for (int k = 0; k < SLOTS; k++) begin
      slot_gen[k]  = '0;
      slot_busy[k] = 1'b0;
    end
    live_slots = 0;
    table_open = 1'b1;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: fill, overflow, handle checks, refused shutdown, presets, generation exhaustion, bad command.
    configure(32'hA5A5_0001, 48'h0000_0000_1000, 16'h0040);
    h = heap_id_reg;
    idle_pct = 20;
    repeat (SLOTS) queue_item(FILL_AS_IS, OP_ALLOC, '0, '0, '0, '0);
    queue_item(FILL_AS_IS, OP_ALLOC, '1, '1, '1, '1);
    queue_item(FILL_AS_IS, OP_LOOKUP, h, 8'(SLOTS - 1), 32'd1, '0);
    queue_item(FILL_AS_IS, OP_RELEASE, h, 8'hFF, 32'd1, '0);
    queue_item(FILL_AS_IS, OP_LOOKUP, h, 8'(SLOTS), 32'd1, '0);
    queue_item(FILL_AS_IS, OP_RELEASE, ~h, 8'd1, 32'd1, '0);
    queue_item(FILL_AS_IS, OP_LOOKUP, h, 8'd1, 32'd2, '0);
    queue_item(FILL_AS_IS, OP_SHUTDOWN, '0, '0, '0, '0);
    queue_item(FILL_AS_IS, OP_PRESET, '0, 8'd0, '0, 32'd5);
    for (int k = 0; k < SLOTS; k++) queue_item(FILL_AS_IS, OP_RELEASE, h, 8'(k), 32'd1, '0);
    queue_item(FILL_AS_IS, OP_RELEASE, h, 8'd0, 32'd1, '0);
    for (int k = 0; k < SLOTS; k++) begin
      queue_item(FILL_AS_IS, OP_PRESET, '0, 8'(k), '0, 32'hFFFF_FFFF);
    end
    queue_item(FILL_AS_IS, OP_PRESET, '0, 8'(SLOTS), '0, '0);
    queue_item(FILL_AS_IS, OP_ALLOC, '0, '0, '0, '0);
    queue_item(FILL_AS_IS, OP_PRESET, '0, 8'd2, '0, 32'hFFFF_FFFE);
    queue_item(FILL_AS_IS, OP_ALLOC, '0, '0, '0, '0);
    queue_item(FILL_AS_IS, OP_ALLOC, '0, '0, '0, '0);
    queue_item(FILL_AS_IS, OP_RELEASE, h, 8'd2, 32'hFFFF_FFFF, '0);
    queue_item(FILL_AS_IS, OP_LOOKUP, h, 8'd2, 32'hFFFF_FFFF, '0);
    queue_item(FILL_AS_IS, 3'(CMD_MAX), '1, '1, '1, '1);
    drain();

    // Random phases, each under its own register setting and idle rate.
    configure(32'd1, 48'd0, 16'd1);
    idle_pct = 30;
    queue_random(310, 1'b0);
    drain();

    configure(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
    idle_pct = 0;
    queue_random(310, 1'b0);
    drain();

    configure($urandom_range(32'hFFFF_FFFF, 1), {16'($urandom), 32'($urandom)},
              16'($urandom_range(16'hFFFF, 1)));
    idle_pct = 15;
    queue_random(310, 1'b0);
    drain();

    configure($urandom_range(32'hFFFF_FFFF, 1), 48'd0, 16'hFFFF);
    idle_pct = 50;
    queue_random(310, 1'b0);
    drain();

    configure($urandom_range(32'hFFFF_FFFF, 1), {16'($urandom), 32'($urandom)},
              16'($urandom_range(16'hFFFF, 1)));
    idle_pct = 10;
    queue_random(310, 1'b0);
    drain();

    // Last part: free every slot, close the table, then hit the closed table.
    configure($urandom_range(32'hFFFF_FFFF, 1), 48'hFFFF_FFFF_FFFF, 16'd1);
    idle_pct = 0;
    repeat (2 * SLOTS) begin
      queue_item(FILL_LIVE, OP_RELEASE, heap_id_reg, '0, '0, '0);
    end
    queue_item(FILL_AS_IS, OP_SHUTDOWN, $urandom, 8'($urandom), $urandom, $urandom);
    queue_random(100, 1'b1);
    drain();

    if (mismatch_count == 0 && predicted_replies.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
